// File: src/psp_pkg.sv
package psp_pkg;

    localparam int DATA_W = 32;
    localparam int ROOT_W = 32;
    localparam int SQ_W   = 2 * ROOT_W;
    localparam int OUT_W  = 34;

    // One classified item handed from the front to the back
    typedef struct packed {
        logic signed [DATA_W-1:0] center;
        logic [DATA_W-1:0]        off_mag;
        logic [DATA_W-1:0]        shear_mag;
        logic signed [DATA_W-1:0] zz;
    } t_job;

    // Queue status seen by the top level
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// File: src/plane_stress_principal_values.sv
// Principal values of a plane stress or strain state by Mohr's circle, signed Q16.16.
// Raise i_start with the four components; the item is taken on any clock edge where
// o_busy is low. One item can be taken every clock while o_busy is low. Each item gives
// exactly one result, shown for a single cycle with o_valid high: the item is written into
// the input queue at the taking edge and leaves it in the next cycle, then the squares are
// registered, then their sum, then the square root stages (one root bit per stage), then
// the output register. Results cannot be held off; capture them when o_valid is high. The
// back end drains the queue every clock, so o_busy stays low in steady operation. The first
// and second principal values are 34 bits wide, the radius (maximum shear) is the truncated
// square root, and z passes through unchanged.
module plane_stress_principal_values
    import psp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic signed [DATA_W-1:0] i_normal_xx,
    input  logic signed [DATA_W-1:0] i_normal_yy,
    input  logic signed [DATA_W-1:0] i_normal_zz,
    input  logic signed [DATA_W-1:0] i_shear_xy,
    output logic                     o_valid,
    output logic signed [OUT_W-1:0]  o_principal_one,
    output logic signed [OUT_W-1:0]  o_principal_two,
    output logic signed [DATA_W-1:0] o_principal_three,
    output logic [ROOT_W-1:0]        o_max_shear
);

    t_job    w_front_job;
    t_job    w_back_job;
    t_q_stat w_q_stat;
    logic    w_push;
    logic    w_pop;

    assign o_busy = w_q_stat.full;
    assign w_push = i_start && !w_q_stat.full;
    assign w_pop  = !w_q_stat.empty;

    // Classify the incoming item
    psp_front u_front (
        .i_normal_xx (i_normal_xx),
        .i_normal_yy (i_normal_yy),
        .i_normal_zz (i_normal_zz),
        .i_shear_xy  (i_shear_xy),
        .o_job       (w_front_job)
    );

    // Hold classified items between front and back
    psp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .i_pop   (w_pop),
        .o_job   (w_back_job),
        .o_stat  (w_q_stat)
    );

    // Square, root and combine
    psp_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_vld             (w_pop),
        .i_job             (w_back_job),
        .o_valid           (o_valid),
        .o_principal_one   (o_principal_one),
        .o_principal_two   (o_principal_two),
        .o_principal_three (o_principal_three),
        .o_max_shear       (o_max_shear)
    );

endmodule

// File: src/psp_front.sv
module psp_front
    import psp_pkg::*;
(
    input  logic signed [DATA_W-1:0] i_normal_xx,
    input  logic signed [DATA_W-1:0] i_normal_yy,
    input  logic signed [DATA_W-1:0] i_normal_zz,
    input  logic signed [DATA_W-1:0] i_shear_xy,
    output t_job                     o_job
);

    logic signed [DATA_W:0] w_sum;
    logic signed [DATA_W:0] w_off;
    logic signed [DATA_W:0] w_shear;
    logic signed [DATA_W:0] w_off_abs;
    logic signed [DATA_W:0] w_shear_abs;

    // Form the center by arithmetic shift of the exact sum, then the magnitudes
    always_comb begin
        w_sum       = {i_normal_xx[DATA_W-1], i_normal_xx}
                    + {i_normal_yy[DATA_W-1], i_normal_yy};
        o_job.center = w_sum[DATA_W:1];
        w_off       = {i_normal_xx[DATA_W-1], i_normal_xx}
                    - {w_sum[DATA_W], w_sum[DATA_W:1]};
        w_shear     = {i_shear_xy[DATA_W-1], i_shear_xy};
        w_off_abs   = w_off[DATA_W] ? -w_off : w_off;
        w_shear_abs = w_shear[DATA_W] ? -w_shear : w_shear;
        o_job.off_mag   = w_off_abs[DATA_W-1:0];
        o_job.shear_mag = w_shear_abs[DATA_W-1:0];
        o_job.zz        = i_normal_zz;
    end

endmodule

// File: src/psp_queue.sv
module psp_queue
    import psp_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_job,
    output t_q_stat o_stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             w_push;
    logic             w_pop;

    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_job        = r_mem[r_rd_ptr];
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && !o_stat.empty;

    // Advance pointers with wrap and track the fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed item
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// File: src/psp_back.sv
module psp_back
    import psp_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_vld,
    input  t_job                     i_job,
    output logic                     o_valid,
    output logic signed [OUT_W-1:0]  o_principal_one,
    output logic signed [OUT_W-1:0]  o_principal_two,
    output logic signed [DATA_W-1:0] o_principal_three,
    output logic [ROOT_W-1:0]        o_max_shear
);

    // Square stage
    logic                     r_sq_vld;
    logic [SQ_W-1:0]          r_sq_a;
    logic [SQ_W-1:0]          r_sq_b;
    logic signed [DATA_W-1:0] r_sq_ctr;
    logic signed [DATA_W-1:0] r_sq_zz;

    // Root pipeline, entry 0 holds the sum of squares
    logic                     r_vld  [ROOT_W+1];
    logic [SQ_W-1:0]          r_rem  [ROOT_W+1];
    logic [ROOT_W-1:0]        r_root [ROOT_W+1];
    logic signed [DATA_W-1:0] r_ctr  [ROOT_W+1];
    logic signed [DATA_W-1:0] r_zz   [ROOT_W+1];

    // Output register
    logic                     r_out_vld;
    logic signed [OUT_W-1:0]  r_p1;
    logic signed [OUT_W-1:0]  r_p2;
    logic signed [DATA_W-1:0] r_p3;
    logic [ROOT_W-1:0]        r_rad;
    logic signed [OUT_W-1:0]  w_ctr_ext;
    logic signed [OUT_W-1:0]  w_rad_ext;

    // Square both magnitudes
    always_ff @(posedge i_clk) begin
        r_sq_a   <= SQ_W'(i_job.off_mag) * SQ_W'(i_job.off_mag);
        r_sq_b   <= SQ_W'(i_job.shear_mag) * SQ_W'(i_job.shear_mag);
        r_sq_ctr <= i_job.center;
        r_sq_zz  <= i_job.zz;
    end

    // Add the squares; the sum stays below 2^64
    always_ff @(posedge i_clk) begin
        r_rem[0]  <= r_sq_a + r_sq_b;
        r_root[0] <= '0;
        r_ctr[0]  <= r_sq_ctr;
        r_zz[0]   <= r_sq_zz;
    end

    // Resolve one root bit per stage, most significant first
    for (genvar g = 0; g < ROOT_W; g++) begin : g_root
        localparam int B = ROOT_W - 1 - g;
        logic [SQ_W-1:0] w_term;
        logic            w_ge;

        always_comb begin
            w_term = (SQ_W'(r_root[g]) << (B + 1)) | (SQ_W'(1) << (2 * B));
            w_ge   = (r_rem[g] >= w_term);
        end

        always_ff @(posedge i_clk) begin
            r_rem[g+1]  <= w_ge ? r_rem[g] - w_term : r_rem[g];
            r_root[g+1] <= w_ge ? (r_root[g] | (ROOT_W'(1) << B)) : r_root[g];
            r_ctr[g+1]  <= r_ctr[g];
            r_zz[g+1]   <= r_zz[g];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else begin
                r_vld[g+1] <= r_vld[g];
            end
        end
    end

    // Form center plus and minus radius
    always_comb begin
        w_ctr_ext = OUT_W'(r_ctr[ROOT_W]);
        w_rad_ext = $signed({{(OUT_W-ROOT_W){1'b0}}, r_root[ROOT_W]});
    end

    always_ff @(posedge i_clk) begin
        r_p1  <= w_ctr_ext + w_rad_ext;
        r_p2  <= w_ctr_ext - w_rad_ext;
        r_p3  <= r_zz[ROOT_W];
        r_rad <= r_root[ROOT_W];
    end

    // Carry the valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld  <= 1'b0;
            r_vld[0]  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_sq_vld  <= i_vld;
            r_vld[0]  <= r_sq_vld;
            r_out_vld <= r_vld[ROOT_W];
        end
    end

    assign o_valid           = r_out_vld;
    assign o_principal_one   = r_p1;
    assign o_principal_two   = r_p2;
    assign o_principal_three = r_p3;
    assign o_max_shear       = r_rad;

endmodule
